### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the offset table checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SOTFL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SOTFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sotfl_pkg.sv
// ---------------------------------------------------------------------------
// sotfl_pkg
// Request/result types and codes for the sorted offset table.
// ---------------------------------------------------------------------------
package sotfl_pkg;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam int POS_W  = 6;
    localparam int DATE_W = 32;
    localparam int OFFS_W = 32;
    localparam int ENTRY_W = DATE_W + OFFS_W;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATE_W-1:0] date_key;
        logic signed [OFFS_W-1:0] offset_value;
    } t_request;

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic signed [OFFS_W-1:0] offset_out;
        logic [1:0]               status;
    } t_result;

endpackage

### sv/sotfl_ram.sv
// ---------------------------------------------------------------------------
// sotfl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module sotfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sorted_offset_table_floor_lookup.sv
// ---------------------------------------------------------------------------
// sorted_offset_table_floor_lookup
// Date-sorted (date, offset) table with insert-before-equal and floor lookup.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  request | in        | i_valid / o_stall  | i_req (opcode, date_key, offset_value)
//  result  | out       | o_valid / i_stall  | o_res (position, offset_out, status)
//
//  One request at a time; the table is walked downward, one RAM read a cycle.
//  A full-table insert or an empty-table lookup skips the scan, and an insert
//  into an empty table goes straight to the write. Reset empties the table at once.
//  A finished result waits in the output register while the next request is
//  taken; if that register is still held by a stall, the block waits too.
// ---------------------------------------------------------------------------
module sorted_offset_table_floor_lookup #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sotfl_pkg::t_request i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output sotfl_pkg::t_result o_res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = (AW > sotfl_pkg::POS_W) ? AW : sotfl_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    // Position field carries the low bits of the index
    function automatic logic [sotfl_pkg::POS_W-1:0] f_pos(input logic [AW-1:0] idx);
        logic [PW-1:0] ext;
        ext = PW'(idx);
        return ext[sotfl_pkg::POS_W-1:0];
    endfunction

    t_state              r_state, n_state;
    sotfl_pkg::t_request r_req, n_req;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_chk_v, n_chk_v;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic [AW-1:0]       r_pos, n_pos;
    sotfl_pkg::t_result  r_res, n_res;
    sotfl_pkg::t_result  r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                          rd_issue;
    logic [AW-1:0]                 rd_addr;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [sotfl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [sotfl_pkg::ENTRY_W-1:0] ram_q;
    logic signed [sotfl_pkg::DATE_W-1:0] q_date;
    logic signed [sotfl_pkg::OFFS_W-1:0] q_offs;
    logic                          q_lt_key;
    logic                          key_lt_q;
    logic                          is_ins;

    // Entry storage: {date, offset}
    sotfl_ram #(
        .WIDTH (sotfl_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Read side of the downward scan
    assign rd_issue = (r_state == S_SCAN) && (r_rd_idx != '0);
    assign rd_addr  = AW'(r_rd_idx - CW'(1));
    assign q_date   = ram_q[sotfl_pkg::ENTRY_W-1:sotfl_pkg::OFFS_W];
    assign q_offs   = ram_q[sotfl_pkg::OFFS_W-1:0];
    assign q_lt_key = q_date < r_req.date_key;
    assign key_lt_q = r_req.date_key < q_date;
    assign is_ins   = (r_req.opcode == sotfl_pkg::OP_INSERT);

    // Control and datapath
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_chk_v     = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_pos       = r_pos;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_chk_idx + AW'(1);
        ram_wdata   = ram_q;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req            = i_req;
                    n_rd_idx         = r_count;
                    n_res.position   = '0;
                    n_res.offset_out = '0;
                    n_res.status     = sotfl_pkg::ST_OK;
                    if (i_req.opcode == sotfl_pkg::OP_INSERT) begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_res.status = sotfl_pkg::ST_FULL;
                            n_state      = S_FIN;
                        end else if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = sotfl_pkg::ST_NOT_FOUND;
                            n_state      = S_FIN;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Keep one read in flight ahead of the compare
                if (rd_issue) begin
                    n_rd_idx  = r_rd_idx - CW'(1);
                    n_chk_v   = 1'b1;
                    n_chk_idx = rd_addr;
                end
                if (r_chk_v) begin
                    if (is_ins) begin
                        if (!q_lt_key) begin
                            // Entry not below the new date: move it up one slot
                            ram_we = 1'b1;
                            if (r_chk_idx == '0) begin
                                n_pos   = '0;
                                n_chk_v = 1'b0;
                                n_state = S_WRITE;
                            end
                        end else begin
                            n_pos   = r_chk_idx + AW'(1);
                            n_chk_v = 1'b0;
                            n_state = S_WRITE;
                        end
                    end else begin
                        if (!key_lt_q) begin
                            n_res.position   = f_pos(r_chk_idx);
                            n_res.offset_out = q_offs;
                            n_chk_v          = 1'b0;
                            n_state          = S_FIN;
                        end else if (r_chk_idx == '0) begin
                            n_res.status = sotfl_pkg::ST_NOT_FOUND;
                            n_state      = S_FIN;
                        end
                    end
                end
            end

            S_WRITE: begin
                ram_we         = 1'b1;
                ram_waddr      = r_pos;
                ram_wdata      = {r_req.date_key, r_req.offset_value};
                n_count        = r_count + CW'(1);
                n_res.position = f_pos(r_pos);
                n_state        = S_FIN;
            end

            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_pos     <= n_pos;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

### sv/sotfl_checker.sv
// ---------------------------------------------------------------------------
// sotfl_checker
// Port-level checks for the sorted offset table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sotfl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input sotfl_pkg::t_result o_res
);

    logic req_taken;
    logic out_held;
    logic res_fail;
    logic res_empty;
    logic status_ok;

    // Port-level conditions used below
    assign req_taken = i_valid && !o_stall;
    assign out_held  = o_valid && i_stall;
    assign res_fail  = o_valid && (o_res.status != sotfl_pkg::ST_OK);
    assign res_empty = (o_res.position == '0) && (o_res.offset_out == '0);
    assign status_ok = (o_res.status == sotfl_pkg::ST_OK)
                    || (o_res.status == sotfl_pkg::ST_NOT_FOUND)
                    || (o_res.status == sotfl_pkg::ST_FULL);

    // Held result stays valid and unchanged
    `SOTFL_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, out_held, o_valid, "stalled result dropped")
    `SOTFL_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, out_held, $stable(o_res), "held result changed")

    // An accepted request makes the block busy
    `SOTFL_ASSERT_NEXT(a_busy, i_clk, i_rst_n, req_taken, o_stall, "not busy after request")

    // A dropped insert or failed lookup carries no position and no offset
    `SOTFL_ASSERT_SAME(a_fail_clean, i_clk, i_rst_n, res_fail, res_empty, "failed result not clean")

    // Only defined status codes leave the block
    `SOTFL_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_valid, status_ok, "undefined status code")

endmodule

bind sorted_offset_table_floor_lookup sotfl_checker u_sotfl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

### tb/tb_sorted_offset_table_floor_lookup.sv
// ---------------------------------------------------------------------------
// tb_sorted_offset_table_floor_lookup
// Self-checking bench for the date-sorted offset table. Requests come from a
// queue that is filled up front: a directed opening, then random inserts and
// floor lookups. A local copy of the table predicts every result, and a
// monitor compares each returned result with the oldest prediction. Both
// channels idle at random, and the result side also holds off once for a
// long stretch.
// ---------------------------------------------------------------------------
module tb_sorted_offset_table_floor_lookup;

    localparam int TBL_DEPTH   = 64;
    localparam int RAND_REQS   = 500;
    localparam int IDLE_PCT    = 34;
    localparam int HOLD_START  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_START  = 9000;
    localparam int CALM_END    = 13000;
    localparam int MAX_REPORTS = 10;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    sotfl_pkg::t_request i_req   = '0;
    logic                o_stall;
    logic                o_valid;
    sotfl_pkg::t_result  o_res;

    sorted_offset_table_floor_lookup #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the table, updated as requests are taken
    logic signed [sotfl_pkg::DATE_W-1:0] tbl_date   [TBL_DEPTH];
    logic signed [sotfl_pkg::OFFS_W-1:0] tbl_offset [TBL_DEPTH];
    int                                  tbl_fill = 0;

    sotfl_pkg::t_request pending_requests [$];
    sotfl_pkg::t_result  expected_results [$];
    int                  error_count = 0;
    bit                  req_taken   = 1'b0;
    int                  cyc         = 0;
    int                  hold_left   = 0;
    logic                calm_window;

    // Stimulus-side bookkeeping: dates already queued for insert
    logic signed [sotfl_pkg::DATE_W-1:0] gen_dates [$];
    int                                  gen_fill = 0;

    assign calm_window = (cyc >= CALM_START) && (cyc < CALM_END);

    // Insert before equal dates; lookup returns the top entry not above the key
    function automatic sotfl_pkg::t_result apply_table_request(sotfl_pkg::t_request req);
        sotfl_pkg::t_result                  res;
        logic signed [sotfl_pkg::DATE_W-1:0] key;
        int                                  pos;
        int                                  idx;
        bit                                  found;
        res   = '0;
        key   = req.date_key;
        pos   = 0;
        found = 1'b0;
        res.status = sotfl_pkg::ST_OK;
        if (req.opcode == sotfl_pkg::OP_INSERT) begin
            if (tbl_fill >= TBL_DEPTH) begin
                res.status = sotfl_pkg::ST_FULL;
            end else begin
                while (pos < tbl_fill && tbl_date[pos] < key) pos++;
                for (idx = tbl_fill; idx > pos; idx--) begin
                    tbl_date[idx]   = tbl_date[idx-1];
                    tbl_offset[idx] = tbl_offset[idx-1];
                end
                tbl_date[pos]   = key;
                tbl_offset[pos] = req.offset_value;
                tbl_fill++;
                res.position = sotfl_pkg::POS_W'(pos);
            end
        end else begin
            idx = tbl_fill - 1;
            while (idx >= 0 && !found) begin
                if (!(key < tbl_date[idx])) found = 1'b1;
                else idx--;
            end
            if (found) begin
                res.position   = sotfl_pkg::POS_W'(idx);
                res.offset_out = tbl_offset[idx];
            end else begin
                res.status = sotfl_pkg::ST_NOT_FOUND;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic queue_request(logic op, logic [31:0] date, logic [31:0] offs);
        sotfl_pkg::t_request req;
        req.opcode       = op;
        req.date_key     = date;
        req.offset_value = offs;
        pending_requests.push_back(req);
        if (op == sotfl_pkg::OP_INSERT && gen_fill < TBL_DEPTH) begin
            gen_fill++;
            gen_dates.push_back(date);
        end
    endtask

    function automatic logic [31:0] pick_insert_date();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30 && gen_dates.size() > 0)
            return gen_dates[$urandom_range(0, gen_dates.size() - 1)];
        else if (roll < 40)
            return pick_extreme();
        else if (roll < 60)
            return 32'($urandom_range(0, 63)) - 32'd32;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_query_date();
        int          roll;
        logic [31:0] base;
        roll = $urandom_range(0, 99);
        base = (gen_dates.size() > 0) ? gen_dates[$urandom_range(0, gen_dates.size() - 1)]
                                      : $urandom;
        if (roll < 40)
            return base;
        else if (roll < 60)
            return $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1;
        else if (roll < 70)
            return pick_extreme();
        return $urandom;
    endfunction

    // Request driver: new request only after the previous one was taken
    always @(negedge i_clk) begin
        bit idle_now;
        if (i_rst_n && (!i_valid || req_taken)) begin
            idle_now = !calm_window && ($urandom_range(0, 99) < IDLE_PCT);
            if (!idle_now && pending_requests.size() > 0) begin
                i_req   <= pending_requests.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Request acceptance: predict the result of each request taken
    always @(posedge i_clk) begin
        req_taken = i_rst_n && i_valid && (o_stall === 1'b0);
        if (req_taken) expected_results.push_back(apply_table_request(i_req));
    end

    // Cycle count and the long result-side hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cyc <= cyc + 1;
            if (cyc == HOLD_START) hold_left <= HOLD_CYCLES;
            else if (hold_left > 0) hold_left <= hold_left - 1;
        end
    end

    // Result-side stall
    always @(negedge i_clk) begin
        if (hold_left > 0) i_stall <= 1'b1;
        else if (calm_window) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Result monitor
    always @(posedge i_clk) begin
        sotfl_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: position %0d offset %h status %0d",
                             o_res.position, o_res.offset_out, o_res.status);
            end else begin
                want = expected_results.pop_front();
                if (o_res.position !== want.position || o_res.offset_out !== want.offset_out
                        || o_res.status !== want.status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: position %0d/%0d offset %h/%h status %0d/%0d",
                                 want.position, o_res.position, want.offset_out,
                                 o_res.offset_out, want.status, o_res.status);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int n;
        // Empty table, then a miss below the only stored date
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(sotfl_pkg::OP_INSERT, 32'h0000_0500, 32'h7FFF_FFFF);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_04FF, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_0500, 32'hDEAD_BEEF);
        // Date extremes and repeated dates
        queue_request(sotfl_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        queue_request(sotfl_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(sotfl_pkg::OP_INSERT, 32'h0000_0500, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_INSERT, 32'h0000_0500, 32'h0001_0000);
        queue_request(sotfl_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        // Floor lookups: oldest of equal dates, neighbors, extremes
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_0500, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_0501, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_04FF, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(sotfl_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        // Random part: fill the table, then mostly lookups on a full table
        for (n = 0; n < RAND_REQS; n++) begin
            if ($urandom_range(0, 99) < ((gen_fill < TBL_DEPTH) ? 50 : 15))
                queue_request(sotfl_pkg::OP_INSERT, pick_insert_date(),
                              ($urandom_range(0, 99) < 20) ? pick_extreme() : $urandom);
            else
                queue_request(sotfl_pkg::OP_LOOKUP, pick_query_date(), $urandom);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TBL_DEPTH + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/sotfl_pkg.sv
sv/sotfl_ram.sv
sv/sorted_offset_table_floor_lookup.sv
sv/sotfl_checker.sv
tb/tb_sorted_offset_table_floor_lookup.sv
